### design/sabcl_pkg.sv
// Shared types, codes and defaults for the block cache lookup.
package sabcl_pkg;

	localparam int DEF_NUM_SETS  = 256;
	localparam int DEF_NUM_WAYS  = 4;
	localparam int DEF_ADDR_BITS = 32;

	localparam int FUNC_W    = 2;
	localparam int IP_W      = 32;
	localparam int WAY_IN_W  = 2;
	localparam int IDX_OUT_W = 10;
	localparam int SET_SHIFT = 3;

	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INVAL  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_MUL,
		ST_QN,
		ST_RD,
		ST_RES
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic qn;
		logic rd;
		logic resolve;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_stall;
	} stat_t;

endpackage

### design/sabcl_if.sv
// Request and response channel interfaces of the block cache lookup.
interface sabcl_req_if import sabcl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [IP_W-1:0]     ip;
	logic [WAY_IN_W-1:0] way;

	modport source (output valid, func, ip, way, input ready);
	modport sink (input valid, func, ip, way, output ready);
endinterface

interface sabcl_rsp_if import sabcl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [WAY_IN_W-1:0]  chosen_way;
	logic [IDX_OUT_W-1:0] entry_index;

	modport source (output valid, hit, chosen_way, entry_index, input ready);
	modport sink (input valid, hit, chosen_way, entry_index, output ready);
endinterface

### design/sabcl_ctrl.sv
// Sequencer for the clear pass and the per-transfer lookup steps.
module sabcl_ctrl import sabcl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLR: begin
				if (stat.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_MUL;
			end
			ST_MUL:  state_nxt = ST_QN;
			ST_QN:   state_nxt = ST_RD;
			ST_RD:   state_nxt = ST_RES;
			ST_RES: begin
				if (!stat.out_stall) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLR:  cmd.clear = 1'b1;
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_QN:   cmd.qn = 1'b1;
			ST_RD:   cmd.rd = 1'b1;
			ST_RES:  cmd.resolve = !stat.out_stall;
			default: cmd = '0;
		endcase
	end

endmodule

### design/sabcl_dp.sv
// Datapath: set index reduction, tag and state rows, way selection, result register.
module sabcl_dp import sabcl_pkg::*; #(
	parameter int NUM_SETS  = DEF_NUM_SETS,
	parameter int NUM_WAYS  = DEF_NUM_WAYS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic [FUNC_W-1:0]    req_func,
	input  logic [IP_W-1:0]      req_ip,
	input  logic [WAY_IN_W-1:0]  req_way,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_hit,
	output logic [WAY_IN_W-1:0]  out_way,
	output logic [IDX_OUT_W-1:0] out_index
);

	localparam int TAG_W = (ADDR_BITS < IP_W) ? ADDR_BITS : IP_W;
	localparam int X_W   = TAG_W - SET_SHIFT;
	localparam int S_W   = $clog2(NUM_SETS);
	localparam int SHIFT = X_W + S_W;
	localparam int R_W   = X_W + 1;
	localparam int P_W   = X_W + R_W;
	localparam int Q_W   = P_W - SHIFT;
	localparam int WAY_W = $clog2(NUM_WAYS);
	localparam int IDX_W = $clog2(NUM_SETS * NUM_WAYS);
	localparam logic [63:0]    RECIP_L = (64'd1 << SHIFT) / 64'(NUM_SETS);
	localparam logic [R_W-1:0] RECIP   = RECIP_L[R_W-1:0];

	logic [FUNC_W-1:0]   func_q;
	logic [TAG_W-1:0]    ip_q;
	logic [WAY_IN_W-1:0] way_q;
	logic [P_W-1:0]      prod_s1;
	logic [X_W-1:0]      qn_s2;
	logic [S_W-1:0]      set_q;
	logic [S_W-1:0]      clr_q;

	logic [NUM_WAYS-1:0][TAG_W-1:0] tag_mem [NUM_SETS];
	logic [NUM_WAYS-1:0]            vld_mem [NUM_SETS];
	logic [WAY_W-1:0]               ptr_mem [NUM_SETS];
	logic [NUM_WAYS-1:0][TAG_W-1:0] tag_rd_q;
	logic [NUM_WAYS-1:0]            vld_rd_q;
	logic [WAY_W-1:0]               ptr_rd_q;

	logic [X_W-1:0]      x;
	logic [Q_W-1:0]      quo;
	logic [X_W-1:0]      diff;
	logic [X_W-1:0]      rem;
	logic [S_W-1:0]      set_nxt;

	logic                any_hit;
	logic                any_inv;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    inv_way;
	logic                way_ok;
	logic [WAY_W-1:0]    wsel;
	logic                res_hit;
	logic [WAY_W-1:0]    res_way;
	logic                res_zero;
	logic                tag_we;
	logic                vld_we;
	logic                ptr_we;
	logic [NUM_WAYS-1:0] vld_new;
	logic [WAY_W-1:0]    ptr_new;
	logic [IDX_W-1:0]    idx;

	assign x       = ip_q[TAG_W-1:SET_SHIFT];
	assign quo     = prod_s1[P_W-1:SHIFT];
	assign diff    = x - qn_s2;
	assign rem     = (diff < X_W'(NUM_SETS)) ? diff : diff - X_W'(NUM_SETS);
	assign set_nxt = rem[S_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= req_func;
			ip_q   <= req_ip[TAG_W-1:0];
			way_q  <= req_way;
		end
		if (cmd.mul) prod_s1 <= P_W'(x) * P_W'(RECIP);
		if (cmd.qn) qn_s2 <= X_W'(X_W'(quo) * X_W'(NUM_SETS));
		if (cmd.rd) set_q <= set_nxt;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) tag_rd_q <= tag_mem[set_nxt];
		if (cmd.resolve && tag_we) tag_mem[set_q][wsel] <= ip_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			vld_rd_q <= vld_mem[set_nxt];
			ptr_rd_q <= ptr_mem[set_nxt];
		end
		if (cmd.clear) begin
			vld_mem[clr_q] <= '0;
			ptr_mem[clr_q] <= '0;
		end else if (cmd.resolve) begin
			if (vld_we) vld_mem[set_q] <= vld_new;
			if (ptr_we) ptr_mem[set_q] <= ptr_new;
		end
	end

	always_comb begin
		any_hit = 1'b0;
		any_inv = 1'b0;
		hit_way = '0;
		inv_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (vld_rd_q[w] && tag_rd_q[w] == ip_q) begin
				any_hit = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!vld_rd_q[w]) begin
				any_inv = 1'b1;
				inv_way = WAY_W'(w);
			end
		end
	end

	assign way_ok  = 32'(way_q) < NUM_WAYS;
	assign wsel    = WAY_W'(way_q);
	assign ptr_new = (32'(ptr_rd_q) == NUM_WAYS - 1) ? '0 : ptr_rd_q + 1'b1;

	always_comb begin
		res_hit  = 1'b0;
		res_way  = '0;
		res_zero = 1'b0;
		tag_we   = 1'b0;
		vld_we   = 1'b0;
		ptr_we   = 1'b0;
		vld_new  = vld_rd_q;
		case (func_q)
			FUNC_LOOKUP: begin
				if (any_hit) begin
					res_hit = 1'b1;
					res_way = hit_way;
				end else if (any_inv) begin
					res_way = inv_way;
				end else begin
					res_way = ptr_rd_q;
					ptr_we  = 1'b1;
				end
			end
			FUNC_FILL, FUNC_INVAL: begin
				if (way_ok) begin
					res_way       = wsel;
					vld_we        = 1'b1;
					tag_we        = (func_q == FUNC_FILL);
					vld_new[wsel] = (func_q == FUNC_FILL);
				end else begin
					res_zero = 1'b1;
				end
			end
			default: res_zero = 1'b1;
		endcase
	end

	assign idx = IDX_W'(set_q) * IDX_W'(NUM_WAYS) + IDX_W'(res_way);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			clr_q     <= '0;
		end else begin
			if (cmd.resolve) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.clear) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			out_hit   <= res_hit;
			out_way   <= res_zero ? '0 : WAY_IN_W'(res_way);
			out_index <= res_zero ? '0 : IDX_OUT_W'(idx);
		end
	end

	assign stat.clr_last  = (32'(clr_q) == NUM_SETS - 1);
	assign stat.out_stall = out_valid && !out_ready;

endmodule

### design/set_assoc_block_cache_lookup.sv
// Top level of the set-associative block cache lookup directory.
// After reset the block clears its valid bits and round-robin pointers, one set per cycle,
// with req.ready low. Then it takes one transfer at a time, through the steps of
// capture, a reciprocal multiply and a back-multiply that reduce the address to a set
// index, a read of the set's tag and state rows, and a resolve step that picks the way,
// writes the row back and loads the result register. The result register holds a finished
// result while the next request is already being taken; the resolve step waits only when
// an earlier result is still untaken. Tags are not cleared: a way reads its tag only once
// a fill has marked it valid.
module set_assoc_block_cache_lookup import sabcl_pkg::*; #(
	parameter int NUM_SETS  = DEF_NUM_SETS,
	parameter int NUM_WAYS  = DEF_NUM_WAYS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input logic         clk,
	input logic         arst_n,
	sabcl_req_if.sink   req,
	sabcl_rsp_if.source rsp
);

	cmd_t  cmd;
	stat_t stat;

	sabcl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sabcl_dp #(
		.NUM_SETS  (NUM_SETS),
		.NUM_WAYS  (NUM_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_func  (req.func),
		.req_ip    (req.ip),
		.req_way   (req.way),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_hit   (rsp.hit),
		.out_way   (rsp.chosen_way),
		.out_index (rsp.entry_index)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.mul, cmd.qn, cmd.rd, cmd.resolve, cmd.clear}))
		else $error("more than one datapath command active");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a transfer is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resolve |-> !(rsp.valid && !rsp.ready))
		else $error("result register overwritten before transfer");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.resolve))
		else $error("result raised without a resolve step");

endmodule
